@@ hw/rtl/trss_pkg.sv @@
// Shared types and constants of the tied rank-sum statistic block.
package trss_pkg;

    // Fixed field widths of the input, output and register transactions
    localparam int QUAL_W      = 6;
    localparam int CNT_IN_W    = 8;
    localparam int CFG_W       = 7;
    localparam int TOTAL_OUT_W = 16;
    localparam int RANK_OUT_W  = 35;

    // Quality bins addressable by the quality field
    localparam int QUAL_SPAN = 64;

    // Register value after reset
    localparam logic [CFG_W-1:0] QBINS_RESET = 7'd64;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_UPD   = 5'b00010,
        ST_CHK   = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // Control from the sequencer to the rank walk pipeline
    typedef struct packed {
        logic clr;
        logic bin_vld;
    } walk_ctl_t;

endpackage

@@ hw/rtl/trss_ram.sv @@
// Generic simple dual-port RAM with a registered read.
module trss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/trss_walk.sv @@
// Rank walk pipeline: midrank per bin, products and saturating rank sums.
module trss_walk #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  trss_pkg::walk_ctl_t                 ctl,
    input  logic [COUNT_WIDTH-1:0]              c0,
    input  logic [COUNT_WIDTH-1:0]              c1,
    output logic                                busy,
    output logic [trss_pkg::RANK_OUT_W-1:0]     sum0,
    output logic [trss_pkg::RANK_OUT_W-1:0]     sum1
);

    import trss_pkg::*;

    localparam int CW     = COUNT_WIDTH;
    localparam int MID_W  = CW + 8;
    localparam int PROD_W = MID_W + CW;
    localparam int EXT_W  = (PROD_W > RANK_OUT_W ? PROD_W : RANK_OUT_W) + 1;
    localparam logic [EXT_W-1:0] SAT_MAX = EXT_W'({RANK_OUT_W{1'b1}});

    logic [CW:0]             here;
    logic [MID_W-1:0]        mid2;
    logic [MID_W-1:0]        rank_reg;
    logic [MID_W-1:0]        rank_next;
    logic                    v1_reg;
    logic                    v2_reg;
    logic [MID_W-1:0]        mid2_reg;
    logic [CW-1:0]           a0_reg;
    logic [CW-1:0]           a1_reg;
    logic [PROD_W-1:0]       prod0_reg;
    logic [PROD_W-1:0]       prod1_reg;
    logic [EXT_W-1:0]        ext0;
    logic [EXT_W-1:0]        ext1;
    logic [RANK_OUT_W-1:0]   sum0_reg;
    logic [RANK_OUT_W-1:0]   sum1_reg;

    // Form twice the midrank of the bin from the combined prior count
    assign here      = (CW + 1)'(c0) + (CW + 1)'(c1);
    assign mid2      = {rank_reg[MID_W-2:0], 1'b0} + MID_W'(here) + MID_W'(1);
    assign rank_next = rank_reg + MID_W'(here);

    // Add each product with saturation at the output range
    assign ext0 = EXT_W'(sum0_reg) + EXT_W'(prod0_reg);
    assign ext1 = EXT_W'(sum1_reg) + EXT_W'(prod1_reg);

    // Control of the pipeline valids, the running rank and the rank sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            rank_reg <= '0;
            sum0_reg <= '0;
            sum1_reg <= '0;
        end
        else if (ctl.clr)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            rank_reg <= '0;
            sum0_reg <= '0;
            sum1_reg <= '0;
        end
        else
        begin
            v1_reg <= ctl.bin_vld;
            v2_reg <= v1_reg;
            if (ctl.bin_vld)
            begin
                rank_reg <= rank_next;
            end
            if (v2_reg)
            begin
                sum0_reg <= (ext0 > SAT_MAX) ? {RANK_OUT_W{1'b1}} : ext0[RANK_OUT_W-1:0];
                sum1_reg <= (ext1 > SAT_MAX) ? {RANK_OUT_W{1'b1}} : ext1[RANK_OUT_W-1:0];
            end
        end
    end

    // Stage the midrank and counts, then the products
    always_ff @(posedge clk)
    begin
        if (ctl.bin_vld)
        begin
            mid2_reg <= mid2;
            a0_reg   <= c0;
            a1_reg   <= c1;
        end
        if (v1_reg)
        begin
            prod0_reg <= PROD_W'(mid2_reg) * PROD_W'(a0_reg);
            prod1_reg <= PROD_W'(mid2_reg) * PROD_W'(a1_reg);
        end
    end

    assign busy = v1_reg | v2_reg;
    assign sum0 = sum0_reg;
    assign sum1 = sum1_reg;

endmodule

@@ hw/rtl/tied_rank_sum_statistic.sv @@
// An item without last_item passes through a bin read, then a write back.
// An item with last_item then passes a check state and, when both alleles are present,
// a walk over each active quality bin and a drain of the rank pipeline before its result
// is loaded; the next item is taken only after the result is loaded.
// A new item is taken only after the read-modify-write of the bin RAM for the last one;
// a result held in a full output register stalls the input. Reset is asynchronous:
// control, totals, bin valid bits and rank sums clear at once, quality_bins returns to 64.
module tied_rank_sum_statistic #(
    parameter int MAX_BINS    = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trss_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                allele,
    input  logic [trss_pkg::QUAL_W-1:0]         quality,
    input  logic [trss_pkg::CNT_IN_W-1:0]       count,
    input  logic                                last_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic [trss_pkg::TOTAL_OUT_W-1:0]    first_total,
    output logic [trss_pkg::TOTAL_OUT_W-1:0]    second_total,
    output logic [trss_pkg::RANK_OUT_W-1:0]     first_rank_sum_x2,
    output logic [trss_pkg::RANK_OUT_W-1:0]     second_rank_sum_x2
);

    import trss_pkg::*;

    localparam int CW        = COUNT_WIDTH;
    localparam int BIN_DEPTH = (MAX_BINS < QUAL_SPAN) ? MAX_BINS : QUAL_SPAN;
    localparam int AW        = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int TEXT_W    = (CW > TOTAL_OUT_W) ? CW : TOTAL_OUT_W;
    localparam logic [CFG_W-1:0] BIN_LIM = CFG_W'(BIN_DEPTH);
    localparam logic [TEXT_W-1:0] TOT_OUT_MAX = TEXT_W'({TOTAL_OUT_W{1'b1}});

    state_t                  state_reg;
    state_t                  state_next;
    logic [CFG_W-1:0]        qbins_reg;
    logic [CFG_W-1:0]        nb;
    logic                    in_acc;
    logic                    allele_reg;
    logic                    last_reg;
    logic                    in_range_reg;
    logic [CNT_IN_W-1:0]     cnt_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [AW-1:0]           ram_raddr;
    logic [2*CW-1:0]         ram_rdata;
    logic [2*CW-1:0]         word_rd;
    logic [2*CW-1:0]         ram_wdata;
    logic                    ram_we;
    logic [CW-1:0]           c0;
    logic [CW-1:0]           c1;
    logic [CW-1:0]           old_cnt;
    logic [CW:0]             bin_sum;
    logic [CW-1:0]           bin_upd;
    logic [1:0][CW-1:0]      tot_reg;
    logic [CW:0]             tot_sum;
    logic [CW-1:0]           tot_upd;
    logic [BIN_DEPTH-1:0]    vld_reg;
    logic [CFG_W-1:0]        walk_idx_reg;
    logic                    pend_reg;
    logic                    status_reg;
    logic                    out_load;
    logic                    out_valid_reg;
    logic                    status_out_reg;
    logic [TOTAL_OUT_W-1:0]  first_total_reg;
    logic [TOTAL_OUT_W-1:0]  second_total_reg;
    logic [RANK_OUT_W-1:0]   first_sum_reg;
    logic [RANK_OUT_W-1:0]   second_sum_reg;
    logic [TEXT_W-1:0]       tot0_ext;
    logic [TEXT_W-1:0]       tot1_ext;
    walk_ctl_t               walk_ctl;
    logic                    walk_busy;
    logic [RANK_OUT_W-1:0]   walk_sum0;
    logic [RANK_OUT_W-1:0]   walk_sum1;

    // Limit the configured bin count to the bins the RAM holds
    assign nb = (qbins_reg > BIN_LIM) ? BIN_LIM : qbins_reg;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qbins_reg <= QBINS_RESET;
        end
        else if (cfg_valid)
        begin
            qbins_reg <= cfg_data;
        end
    end

    // Input transaction accepted only between items
    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid & in_ready;

    // Read the addressed bin on accept, otherwise the walk bin
    assign ram_raddr = (state_reg == ST_IDLE) ? quality[AW-1:0] : walk_idx_reg[AW-1:0];

    // Bins never written since the last clear read as zero
    assign word_rd = vld_reg[rd_addr_reg] ? ram_rdata : '0;
    assign c0      = word_rd[CW-1:0];
    assign c1      = word_rd[2*CW-1:CW];

    // Saturating update of the bin count and the allele total
    assign old_cnt   = allele_reg ? c1 : c0;
    assign bin_sum   = (CW + 1)'(old_cnt) + (CW + 1)'(cnt_reg);
    assign bin_upd   = bin_sum[CW] ? {CW{1'b1}} : bin_sum[CW-1:0];
    assign tot_sum   = (CW + 1)'(tot_reg[allele_reg]) + (CW + 1)'(cnt_reg);
    assign tot_upd   = tot_sum[CW] ? {CW{1'b1}} : tot_sum[CW-1:0];
    assign ram_wdata = allele_reg ? {bin_upd, c0} : {c1, bin_upd};
    assign ram_we    = (state_reg == ST_UPD) & in_range_reg;

    trss_ram #(
        .WIDTH (2 * CW),
        .DEPTH (BIN_DEPTH)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rd_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Load the result once the output register is free
    assign out_load = (state_reg == ST_OUT) & (~out_valid_reg | out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = last_reg ? ST_CHK : ST_IDLE;
            end
            ST_CHK:
            begin
                if (tot_reg[0] == '0 || tot_reg[1] == '0 || nb == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_idx_reg >= nb && !pend_reg && !walk_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, totals and bin valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tot_reg      <= '0;
            vld_reg      <= '0;
            walk_idx_reg <= '0;
            pend_reg     <= 1'b0;
            status_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_WALK) && (walk_idx_reg < nb);
            if (ram_we)
            begin
                vld_reg[rd_addr_reg]  <= 1'b1;
                tot_reg[allele_reg]   <= tot_upd;
            end
            if (state_reg == ST_CHK)
            begin
                walk_idx_reg <= '0;
                status_reg   <= (tot_reg[0] == '0) || (tot_reg[1] == '0);
            end
            else if (state_reg == ST_WALK && walk_idx_reg < nb)
            begin
                walk_idx_reg <= walk_idx_reg + CFG_W'(1);
            end
            if (out_load)
            begin
                tot_reg <= '0;
                vld_reg <= '0;
            end
        end
    end

    // Hold the fields of the accepted transaction and the read address
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= ram_raddr;
        if (in_acc)
        begin
            allele_reg   <= allele;
            last_reg     <= last_item;
            cnt_reg      <= count;
            in_range_reg <= (CFG_W'(quality) < nb);
        end
    end

    // Rank walk pipeline
    assign walk_ctl.clr     = out_load;
    assign walk_ctl.bin_vld = pend_reg;

    trss_walk #(
        .COUNT_WIDTH (CW)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (walk_ctl),
        .c0    (c0),
        .c1    (c1),
        .busy  (walk_busy),
        .sum0  (walk_sum0),
        .sum1  (walk_sum1)
    );

    // Limit the totals to the output range
    assign tot0_ext = TEXT_W'(tot_reg[0]);
    assign tot1_ext = TEXT_W'(tot_reg[1]);

    // Output register: valid until the result transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_out_reg   <= status_reg;
            first_total_reg  <= (tot0_ext > TOT_OUT_MAX) ? {TOTAL_OUT_W{1'b1}}
                                                          : tot0_ext[TOTAL_OUT_W-1:0];
            second_total_reg <= (tot1_ext > TOT_OUT_MAX) ? {TOTAL_OUT_W{1'b1}}
                                                          : tot1_ext[TOTAL_OUT_W-1:0];
            first_sum_reg    <= status_reg ? '0 : walk_sum0;
            second_sum_reg   <= status_reg ? '0 : walk_sum1;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_out_reg;
    assign first_total        = first_total_reg;
    assign second_total       = second_total_reg;
    assign first_rank_sum_x2  = first_sum_reg;
    assign second_rank_sum_x2 = second_sum_reg;

    // A missing allele reports zero rank sums
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> first_rank_sum_x2 == '0 && second_rank_sum_x2 == '0)
        else $error("rank sums not zero with a missing allele");

    // The site state is empty after each result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> tot_reg == '0 && vld_reg == '0 && walk_sum0 == '0 && walk_sum1 == '0)
        else $error("site state not cleared after result");

    // The walk pipeline is empty whenever a new transaction may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !walk_busy && !pend_reg)
        else $error("walk pipeline busy between sites");

    // Bin reads of the walk never pass the active bin count
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(walk_idx_reg) < nb)
        else $error("walk read beyond active bins");

    // The RAM is written only on an in-range update
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> $past(in_acc) && $past(CFG_W'(quality) < nb))
        else $error("bin write without an in-range transaction");

endmodule
